@@ rtl/core/bptc_pkg.sv @@
// Shared constants, stage types and arithmetic helpers for the barometer
// compensation core. No dependencies; used by baro_temp_press_compensation_core.
package bptc_pkg;

   // converter resolution: only the low RAW_WIDTH bits of a raw sample count
   localparam int RAW_WIDTH = 24;

   // pipeline depth, output register included
   localparam int NUM_STAGES = 17;

   // output range limits
   localparam int TEMP_LOW   = -4000;
   localparam int TEMP_HIGH  = 8500;
   localparam int PRESS_LOW  = 3000000;
   localparam int PRESS_HIGH = 12500000;

   // configuration register indexes
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 48;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_TEMP_CALIB    = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_PRESS_CALIB_A = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_PRESS_CALIB_B = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_PRESS_CALIB_C = 2'd3;

   // divide by 2**n, truncating toward zero
   function automatic logic signed [79:0] trunc_shift(input logic signed [79:0] x,
                                                     input int unsigned n);
      logic signed [79:0] bias;
      bias = x[79] ? ((80'sd1 <<< n) - 80'sd1) : 80'sd0;
      return (x + bias) >>> n;
   endfunction

   // one decimal long-division digit: returns {quotient[7:0], remainder[3:0]}
   function automatic logic [11:0] div10_step(input logic [3:0] rem, input logic [7:0] chunk);
      logic [11:0] v;
      logic [27:0] p;
      logic [7:0]  q;
      logic [11:0] r;
      v = {rem, chunk};
      p = 28'(v) * 28'd52429;
      q = p[26:19];
      r = v - (12'(q) * 12'd10);
      return {q, r[3:0]};
   endfunction

   typedef struct {
      logic signed [26:0] d;
      logic [23:0]        rp;
   } stg1_type;

   typedef struct {
      logic signed [43:0] a;
      logic signed [53:0] dd;
      logic [47:0]        rpsq;
      logic [23:0]        rp;
   } stg2_type;

   typedef struct {
      logic signed [62:0] n;
      logic signed [56:0] q7n;
      logic [23:0]        rp;
   } stg3_type;

   typedef struct {
      logic signed [28:0] tl;
      logic signed [40:0] q7;
      logic [23:0]        rp;
   } stg4_type;

   typedef struct {
      logic signed [33:0] t25;
      logic signed [57:0] td;
      logic signed [37:0] q3;
      logic signed [45:0] q7rh;
      logic signed [45:0] q7rl;
      logic signed [45:0] e6;
      logic signed [45:0] e2;
      logic signed [28:0] tl;
      logic [23:0]        rp;
   } stg5_type;

   typedef struct {
      logic signed [14:0] temp;
      logic               tcl;
      logic [47:0]        dq;
      logic signed [62:0] q4n;
      logic signed [66:0] q7rp;
      logic signed [65:0] fd7;
      logic signed [65:0] fd3;
      logic signed [45:0] e6;
      logic signed [45:0] e2;
      logic signed [28:0] tl;
      logic [23:0]        rp;
   } stg6_type;

   typedef struct {
      logic signed [14:0] temp;
      logic               tcl;
      logic signed [53:0] ph;
      logic signed [53:0] pl;
      logic [47:0]        mag;
      logic               q4neg;
      logic signed [59:0] q7t;
      logic signed [71:0] off_a;
      logic signed [71:0] sens_a;
      logic [23:0]        rp;
   } stg7_type;

   typedef struct {
      logic signed [14:0] temp;
      logic               tcl;
      logic signed [77:0] prod;
      logic [23:0]        qhi;
      logic [3:0]         rem;
      logic [23:0]        mlo;
      logic               q4neg;
      logic signed [59:0] q7t;
      logic signed [71:0] off_a;
      logic signed [71:0] sens_a;
      logic [23:0]        rp;
   } stg8_type;

   typedef struct {
      logic signed [14:0] temp;
      logic               tcl;
      logic signed [69:0] d3;
      logic signed [44:0] q10;
      logic signed [59:0] q7t;
      logic signed [71:0] off_a;
      logic signed [71:0] sens_a;
      logic [23:0]        rp;
   } stg9_type;

   typedef struct {
      logic signed [14:0] temp;
      logic               tcl;
      logic signed [77:0] d3p8;
      logic signed [77:0] d3p4;
      logic signed [47:0] rqh;
      logic signed [47:0] rql;
      logic signed [59:0] q7t;
      logic signed [71:0] off_a;
      logic signed [71:0] sens_a;
      logic [23:0]        rp;
   } stg10_type;

   typedef struct {
      logic signed [14:0] temp;
      logic               tcl;
      logic signed [72:0] off;
      logic signed [72:0] sens;
      logic signed [70:0] rq;
      logic signed [59:0] q7t;
      logic [23:0]        rp;
   } stg11_type;

   typedef struct {
      logic signed [14:0] temp;
      logic               tcl;
      logic signed [70:0] offq;
      logic signed [48:0] sh;
      logic signed [61:0] q4t;
      logic signed [59:0] q7t;
      logic [23:0]        rp;
   } stg12_type;

   typedef struct {
      logic signed [14:0] temp;
      logic               tcl;
      logic signed [49:0] srh;
      logic signed [49:0] srl;
      logic signed [72:0] c;
   } stg13_type;

   typedef struct {
      logic signed [14:0] temp;
      logic               tcl;
      logic signed [74:0] tot;
   } stg14_type;

   typedef struct {
      logic signed [14:0] temp;
      logic               tcl;
      logic signed [79:0] tp;
   } stg15_type;

   typedef struct {
      logic signed [14:0] temp;
      logic               tcl;
      logic signed [40:0] pr;
   } stg16_type;

   typedef struct {
      logic signed [14:0] temp;
      logic               tcl;
      logic [23:0]        press;
      logic               pcl;
   } stg17_type;

endpackage

@@ rtl/core/baro_temp_press_compensation_core.sv @@
// Barometer temperature and pressure compensation core, pipelined.
// Depends on bptc_pkg for constants, stage types and helper functions.
//
// Usage:
//   req_*  carries one raw temperature / raw pressure sample pair per transfer.
//   rsp_*  returns one compensated result per sample pair, in order.
//   csr_*  writes the four calibration registers (index 0..3); always ready.
//          Write them only while no sample is in flight.
// The pipeline has 17 register stages between an accepted request transfer
// and rsp_tvalid: each one holds a few multipliers of at most about 32x32
// bits, a wide add, or a multiply feeding one add, and the divide by ten runs
// as six decimal digit steps over two stages. Throughput is one sample pair
// per cycle while the receiver does not stall.
// Each stage carries a valid bit and advances when it is empty or when the
// stage after it advances, so bubbles are squeezed out and req_tready drops
// only when every stage holds an item and the receiver stalls. A stalled
// result holds in the output register; nothing is lost or repeated.
// Reset clears all valid bits and sets every calibration register to zero.
module baro_temp_press_compensation_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // raw_temperature[23:0], raw_pressure[47:24]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // temperature_centi[14:0], pressure_centi[38:15], pad
   output logic [1:0]  rsp_tuser,   // temperature_clamped[0], pressure_clamped[1]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [bptc_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [bptc_pkg::CSR_DATA_WIDTH-1:0]  csr_data
);

   localparam int NS = bptc_pkg::NUM_STAGES;

   // calibration registers
   logic [39:0] tcal_ff;
   logic [47:0] pcal_a_ff;
   logic [47:0] pcal_b_ff;
   logic [31:0] pcal_c_ff;

   // calibration fields
   logic [15:0]        t1_u, t2_u, p5_u, p6_u;
   logic signed [7:0]  t3_s, p3_s, p4_s, p7_s, p8_s, p10_s, p11_s;
   logic signed [15:0] p1_s, p2_s, p9_s;

   // pipeline control
   logic [NS:1]   vld_ff;
   logic [NS:1]   vld_in;
   logic [NS+1:1] adv;

   bptc_pkg::stg1_type  st1_in,  st1_ff;
   bptc_pkg::stg2_type  st2_in,  st2_ff;
   bptc_pkg::stg3_type  st3_in,  st3_ff;
   bptc_pkg::stg4_type  st4_in,  st4_ff;
   bptc_pkg::stg5_type  st5_in,  st5_ff;
   bptc_pkg::stg6_type  st6_in,  st6_ff;
   bptc_pkg::stg7_type  st7_in,  st7_ff;
   bptc_pkg::stg8_type  st8_in,  st8_ff;
   bptc_pkg::stg9_type  st9_in,  st9_ff;
   bptc_pkg::stg10_type st10_in, st10_ff;
   bptc_pkg::stg11_type st11_in, st11_ff;
   bptc_pkg::stg12_type st12_in, st12_ff;
   bptc_pkg::stg13_type st13_in, st13_ff;
   bptc_pkg::stg14_type st14_in, st14_ff;
   bptc_pkg::stg15_type st15_in, st15_ff;
   bptc_pkg::stg16_type st16_in, st16_ff;
   bptc_pkg::stg17_type st17_in, st17_ff;

   // ---------------------------------------------------------------------
   // Configuration writes
   // ---------------------------------------------------------------------
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tcal_ff   <= '0;
         pcal_a_ff <= '0;
         pcal_b_ff <= '0;
         pcal_c_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            bptc_pkg::REG_TEMP_CALIB:    tcal_ff   <= csr_data[39:0];
            bptc_pkg::REG_PRESS_CALIB_A: pcal_a_ff <= csr_data;
            bptc_pkg::REG_PRESS_CALIB_B: pcal_b_ff <= csr_data;
            bptc_pkg::REG_PRESS_CALIB_C: pcal_c_ff <= csr_data[31:0];
            default: ;
         endcase
      end
   end

   // unpack calibration coefficients
   assign t1_u  = tcal_ff[39:24];
   assign t2_u  = tcal_ff[23:8];
   assign t3_s  = $signed(tcal_ff[7:0]);
   assign p1_s  = $signed(pcal_a_ff[47:32]);
   assign p2_s  = $signed(pcal_a_ff[31:16]);
   assign p3_s  = $signed(pcal_a_ff[15:8]);
   assign p4_s  = $signed(pcal_a_ff[7:0]);
   assign p5_u  = pcal_b_ff[47:32];
   assign p6_u  = pcal_b_ff[31:16];
   assign p7_s  = $signed(pcal_b_ff[15:8]);
   assign p8_s  = $signed(pcal_b_ff[7:0]);
   assign p9_s  = $signed(pcal_c_ff[31:16]);
   assign p10_s = $signed(pcal_c_ff[15:8]);
   assign p11_s = $signed(pcal_c_ff[7:0]);

   // ---------------------------------------------------------------------
   // Pipeline advance: a stage moves when empty or when its successor moves
   // ---------------------------------------------------------------------
   always_comb begin
      adv[NS+1] = rsp_tready;
      for (int k = NS; k >= 1; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
   end

   assign vld_in     = {vld_ff[NS-1:1], req_tvalid};
   assign req_tready = adv[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 1; k <= NS; k++) begin
            if (adv[k]) vld_ff[k] <= vld_in[k];
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stage 1: temperature offset from calibration point
   // ---------------------------------------------------------------------
   always_comb begin : s1_comb
      logic [26:0] rt_x;
      logic [26:0] t1_x;
      rt_x = 27'(req_tdata[bptc_pkg::RAW_WIDTH-1:0]);
      t1_x = {3'b000, t1_u, 8'h00};
      st1_in.d  = $signed(rt_x) - $signed(t1_x);
      st1_in.rp = 24'(req_tdata[24 +: bptc_pkg::RAW_WIDTH]);
   end

   // Stage 2: linear and square terms, pressure square
   always_comb begin : s2_comb
      logic signed [16:0] t2_x;
      t2_x = $signed({1'b0, t2_u});
      st2_in.a    = t2_x * st1_ff.d;
      st2_in.dd   = st1_ff.d * st1_ff.d;
      st2_in.rpsq = st1_ff.rp * st1_ff.rp;
      st2_in.rp   = st1_ff.rp;
   end

   // Stage 3: temperature polynomial numerator, pressure quadratic coefficient
   always_comb begin : s3_comb
      logic signed [62:0] a_sh;
      logic signed [62:0] dd_t3;
      logic signed [48:0] rpsq_x;
      a_sh   = 63'(st2_ff.a) <<< 18;
      dd_t3  = st2_ff.dd * t3_s;
      rpsq_x = $signed({1'b0, st2_ff.rpsq});
      st3_in.n   = a_sh + dd_t3;
      st3_in.q7n = rpsq_x * p11_s;
      st3_in.rp  = st2_ff.rp;
   end

   // Stage 4: linearized temperature term
   always_comb begin : s4_comb
      st4_in.tl = 29'(bptc_pkg::trunc_shift(st3_ff.n, 32));
      st4_in.q7 = 41'(bptc_pkg::trunc_shift(st3_ff.q7n, 16));
      st4_in.rp = st3_ff.rp;
   end

   // Stage 5: square of t_lin, first products of the pressure terms
   always_comb begin : s5_comb
      logic signed [33:0] tl_x;
      logic signed [37:0] q3a;
      logic signed [37:0] q3b;
      logic signed [24:0] rp_x;
      logic signed [16:0] p2m;
      tl_x = 34'(st4_ff.tl);
      q3a  = p10_s * st4_ff.tl;
      q3b  = 38'(p9_s) <<< 16;
      rp_x = $signed({1'b0, st4_ff.rp});
      p2m  = 17'(p2_s) - 17'sd16384;
      st5_in.t25  = (tl_x <<< 4) + (tl_x <<< 3) + tl_x;
      st5_in.td   = st4_ff.tl * st4_ff.tl;
      st5_in.q3   = q3a + q3b;
      st5_in.q7rh = $signed(st4_ff.q7[40:20]) * rp_x;
      st5_in.q7rl = $signed({1'b0, st4_ff.q7[19:0]}) * rp_x;
      st5_in.e6   = st4_ff.tl * $signed({1'b0, p6_u});
      st5_in.e2   = st4_ff.tl * p2m;
      st5_in.tl   = st4_ff.tl;
      st5_in.rp   = st4_ff.rp;
   end

   // Stage 6: finish temperature, square terms of offset and sensitivity
   always_comb begin : s6_comb
      logic signed [19:0] temp_w;
      logic signed [24:0] rp_x;
      temp_w = 20'(bptc_pkg::trunc_shift(st5_ff.t25, 14));
      rp_x   = $signed({1'b0, st5_ff.rp});
      if (temp_w < bptc_pkg::TEMP_LOW) begin
         st6_in.temp = 15'(bptc_pkg::TEMP_LOW);
         st6_in.tcl  = 1'b1;
      end else if (temp_w > bptc_pkg::TEMP_HIGH) begin
         st6_in.temp = 15'(bptc_pkg::TEMP_HIGH);
         st6_in.tcl  = 1'b1;
      end else begin
         st6_in.temp = 15'(temp_w);
         st6_in.tcl  = 1'b0;
      end
      st6_in.dq   = st5_ff.td[53:6];
      st6_in.q4n  = st5_ff.q3 * rp_x;
      st6_in.q7rp = (67'(st5_ff.q7rh) <<< 20) + 67'(st5_ff.q7rl);
      st6_in.fd7  = st5_ff.td * p7_s;
      st6_in.fd3  = st5_ff.td * p3_s;
      st6_in.e6   = st5_ff.e6;
      st6_in.e2   = st5_ff.e2;
      st6_in.tl   = st5_ff.tl;
      st6_in.rp   = st5_ff.rp;
   end

   // Stage 7: cube partials, offset and sensitivity partial sums
   always_comb begin : s7_comb
      logic signed [49:0] q4;
      logic signed [49:0] mag_w;
      logic signed [16:0] p1m;
      p1m   = 17'(p1_s) - 17'sd16384;
      q4    = 50'(bptc_pkg::trunc_shift(st6_ff.q4n, 13));
      mag_w = q4[49] ? -q4 : q4;
      st7_in.temp   = st6_ff.temp;
      st7_in.tcl    = st6_ff.tcl;
      st7_in.ph     = $signed({1'b0, st6_ff.dq[47:24]}) * st6_ff.tl;
      st7_in.pl     = $signed({1'b0, st6_ff.dq[23:0]}) * st6_ff.tl;
      st7_in.mag    = mag_w[47:0];
      st7_in.q4neg  = q4[49];
      st7_in.q7t    = 60'(bptc_pkg::trunc_shift(st6_ff.q7rp, 7));
      st7_in.off_a  = (72'($signed({1'b0, p5_u})) <<< 47) + (72'(st6_ff.fd7) <<< 4)
                      + (72'(st6_ff.e6) <<< 22);
      st7_in.sens_a = (72'(p1m) <<< 46) + (72'(st6_ff.fd3) <<< 2)
                      + (72'(st6_ff.e2) <<< 21);
      st7_in.rp     = st6_ff.rp;
   end

   // Stage 8: combine cube partials, upper decimal digits of q4 / 10
   always_comb begin : s8_comb
      logic [11:0] da, db, dc;
      da = bptc_pkg::div10_step(4'd0, st7_ff.mag[47:40]);
      db = bptc_pkg::div10_step(da[3:0], st7_ff.mag[39:32]);
      dc = bptc_pkg::div10_step(db[3:0], st7_ff.mag[31:24]);
      st8_in.temp   = st7_ff.temp;
      st8_in.tcl    = st7_ff.tcl;
      st8_in.prod   = (78'(st7_ff.ph) <<< 24) + 78'(st7_ff.pl);
      st8_in.qhi    = {da[11:4], db[11:4], dc[11:4]};
      st8_in.rem    = dc[3:0];
      st8_in.mlo    = st7_ff.mag[23:0];
      st8_in.q4neg  = st7_ff.q4neg;
      st8_in.q7t    = st7_ff.q7t;
      st8_in.off_a  = st7_ff.off_a;
      st8_in.sens_a = st7_ff.sens_a;
      st8_in.rp     = st7_ff.rp;
   end

   // Stage 9: scaled cube, lower decimal digits and sign of q4 / 10
   always_comb begin : s9_comb
      logic [11:0] dd_a, dd_b, dd_c;
      logic [47:0] q;
      logic signed [44:0] qs;
      dd_a = bptc_pkg::div10_step(st8_ff.rem, st8_ff.mlo[23:16]);
      dd_b = bptc_pkg::div10_step(dd_a[3:0], st8_ff.mlo[15:8]);
      dd_c = bptc_pkg::div10_step(dd_b[3:0], st8_ff.mlo[7:0]);
      q    = {st8_ff.qhi, dd_a[11:4], dd_b[11:4], dd_c[11:4]};
      qs   = $signed({1'b0, q[43:0]});
      st9_in.temp   = st8_ff.temp;
      st9_in.tcl    = st8_ff.tcl;
      st9_in.d3     = 70'(bptc_pkg::trunc_shift(st8_ff.prod, 8));
      st9_in.q10    = st8_ff.q4neg ? -qs : qs;
      st9_in.q7t    = st8_ff.q7t;
      st9_in.off_a  = st8_ff.off_a;
      st9_in.sens_a = st8_ff.sens_a;
      st9_in.rp     = st8_ff.rp;
   end

   // Stage 10: cube coefficient products, raw pressure times q4 / 10
   always_comb begin : s10_comb
      logic signed [24:0] rp_x;
      rp_x = $signed({1'b0, st9_ff.rp});
      st10_in.temp   = st9_ff.temp;
      st10_in.tcl    = st9_ff.tcl;
      st10_in.d3p8   = st9_ff.d3 * p8_s;
      st10_in.d3p4   = st9_ff.d3 * p4_s;
      st10_in.rqh    = $signed(st9_ff.q10[44:22]) * rp_x;
      st10_in.rql    = $signed({1'b0, st9_ff.q10[21:0]}) * rp_x;
      st10_in.q7t    = st9_ff.q7t;
      st10_in.off_a  = st9_ff.off_a;
      st10_in.sens_a = st9_ff.sens_a;
      st10_in.rp     = st9_ff.rp;
   end

   // Stage 11: complete offset and sensitivity
   always_comb begin : s11_comb
      st11_in.temp = st10_ff.temp;
      st11_in.tcl  = st10_ff.tcl;
      st11_in.off  = 73'(st10_ff.off_a) + 73'(bptc_pkg::trunc_shift(st10_ff.d3p8, 5));
      st11_in.sens = 73'(st10_ff.sens_a) + 73'(bptc_pkg::trunc_shift(st10_ff.d3p4, 5));
      st11_in.rq   = (71'(st10_ff.rqh) <<< 22) + 71'(st10_ff.rql);
      st11_in.q7t  = st10_ff.q7t;
      st11_in.rp   = st10_ff.rp;
   end

   // Stage 12: scale the pressure polynomial terms
   always_comb begin : s12_comb
      st12_in.temp = st11_ff.temp;
      st12_in.tcl  = st11_ff.tcl;
      st12_in.offq = 71'(bptc_pkg::trunc_shift(st11_ff.off, 2));
      st12_in.sh   = 49'(bptc_pkg::trunc_shift(st11_ff.sens, 24));
      st12_in.q4t  = 62'(bptc_pkg::trunc_shift(st11_ff.rq, 9));
      st12_in.q7t  = st11_ff.q7t;
      st12_in.rp   = st11_ff.rp;
   end

   // Stage 13: sensitivity times raw pressure, sum of the other terms
   always_comb begin : s13_comb
      logic signed [24:0] rp_x;
      logic signed [72:0] q4x;
      rp_x = $signed({1'b0, st12_ff.rp});
      q4x  = 73'(st12_ff.q4t);
      st13_in.temp = st12_ff.temp;
      st13_in.tcl  = st12_ff.tcl;
      st13_in.srh  = $signed(st12_ff.sh[48:24]) * rp_x;
      st13_in.srl  = $signed({1'b0, st12_ff.sh[23:0]}) * rp_x;
      st13_in.c    = 73'(st12_ff.offq) + (q4x <<< 3) + (q4x <<< 1) + 73'(st12_ff.q7t);
   end

   // Stage 14: total
   always_comb begin : s14_comb
      st14_in.temp = st13_ff.temp;
      st14_in.tcl  = st13_ff.tcl;
      st14_in.tot  = 75'(st13_ff.c) + (75'(st13_ff.srh) <<< 24) + 75'(st13_ff.srl);
   end

   // Stage 15: scale by 25
   always_comb begin : s15_comb
      logic signed [79:0] tx;
      tx = 80'(st14_ff.tot);
      st15_in.temp = st14_ff.temp;
      st15_in.tcl  = st14_ff.tcl;
      st15_in.tp   = (tx <<< 4) + (tx <<< 3) + tx;
   end

   // Stage 16: pressure in hundredths of a pascal
   always_comb begin : s16_comb
      st16_in.temp = st15_ff.temp;
      st16_in.tcl  = st15_ff.tcl;
      st16_in.pr   = 41'(bptc_pkg::trunc_shift(st15_ff.tp, 40));
   end

   // Stage 17: clamp pressure into the output register
   always_comb begin : s17_comb
      st17_in.temp = st16_ff.temp;
      st17_in.tcl  = st16_ff.tcl;
      if (st16_ff.pr < bptc_pkg::PRESS_LOW) begin
         st17_in.press = 24'(bptc_pkg::PRESS_LOW);
         st17_in.pcl   = 1'b1;
      end else if (st16_ff.pr > bptc_pkg::PRESS_HIGH) begin
         st17_in.press = 24'(bptc_pkg::PRESS_HIGH);
         st17_in.pcl   = 1'b1;
      end else begin
         st17_in.press = st16_ff.pr[23:0];
         st17_in.pcl   = 1'b0;
      end
   end

   // advance the stage payloads
   always_ff @(posedge clock) begin
      if (adv[1])  st1_ff  <= st1_in;
      if (adv[2])  st2_ff  <= st2_in;
      if (adv[3])  st3_ff  <= st3_in;
      if (adv[4])  st4_ff  <= st4_in;
      if (adv[5])  st5_ff  <= st5_in;
      if (adv[6])  st6_ff  <= st6_in;
      if (adv[7])  st7_ff  <= st7_in;
      if (adv[8])  st8_ff  <= st8_in;
      if (adv[9])  st9_ff  <= st9_in;
      if (adv[10]) st10_ff <= st10_in;
      if (adv[11]) st11_ff <= st11_in;
      if (adv[12]) st12_ff <= st12_in;
      if (adv[13]) st13_ff <= st13_in;
      if (adv[14]) st14_ff <= st14_in;
      if (adv[15]) st15_ff <= st15_in;
      if (adv[16]) st16_ff <= st16_in;
      if (adv[17]) st17_ff <= st17_in;
   end

   // drive the result channel
   assign rsp_tvalid = vld_ff[NS];
   assign rsp_tdata  = {1'b0, st17_ff.press, st17_ff.temp};
   assign rsp_tuser  = {st17_ff.pcl, st17_ff.tcl};

endmodule
